// ----- hdl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- hdl/afbp_pkg.sv -----
// ----------------------------------------------------------------------------
// afbp_pkg
// Shared types and constants of the audio frame buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none
package afbp_pkg;
    localparam int NUM_BUFFERS = 16;
    localparam int MAX_FRAME   = 512;
    localparam int BUF_W       = $clog2(NUM_BUFFERS);
    localparam int OFF_W       = $clog2(MAX_FRAME);
    localparam int FILL_W      = $clog2(MAX_FRAME + 1);
    localparam int ADDR_W      = BUF_W + OFF_W;
    localparam int CFG_W       = 10;
    localparam int LEN_W       = 10;
    localparam int QDEPTH      = 2;

    typedef enum logic [1:0] {
        MODE_PUSH  = 2'd0,
        MODE_POP   = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic {
        CFG_FRAME_LEN = 1'b0,
        CFG_CAPTURE   = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_READ = 2'd1,
        ST_SEND = 2'd2
    } back_state_t;

    // One classified word travelling from the front to the back.
    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] sample;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic               valid;
        logic signed [15:0] sample;
        logic [31:0]        seq;
        logic               last_of_frame;
        logic               dropped;
    } result_t;
endpackage
`default_nettype wire

// ----- hdl/afbp_stream_if.sv -----
// ----------------------------------------------------------------------------
// afbp_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`default_nettype none
interface afbp_in_if;
    logic valid;
    logic ready;
    logic [1:0] mode;
    logic signed [15:0] sample_in;
    logic last_of_block;
    modport source (output valid, mode, sample_in, last_of_block, input ready);
    modport sink (input valid, mode, sample_in, last_of_block, output ready);
endinterface

interface afbp_out_if;
    logic valid;
    logic ready;
    logic out_valid;
    logic signed [15:0] sample_out;
    logic [31:0] out_frame_seq;
    logic last_of_frame;
    logic push_dropped;
    modport source (output valid, out_valid, sample_out, out_frame_seq, last_of_frame,
                    push_dropped, input ready);
    modport sink (input valid, out_valid, sample_out, out_frame_seq, last_of_frame,
                  push_dropped, output ready);
endinterface
`default_nettype wire

// ----- hdl/afbp_front.sv -----
// ----------------------------------------------------------------------------
// afbp_front
// Accepts input words and queues them as commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module afbp_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    afbp_in_if.sink              in_ch,
    output afbp_pkg::cmd_t       cmd,
    output logic                 cmd_valid,
    input  wire logic            cmd_pop
);
    afbp_pkg::cmd_t q_reg [afbp_pkg::QDEPTH];
    logic [1:0] count_reg, count_next;
    logic       rd_reg, rd_next;
    logic       wr_reg, wr_next;
    logic       push;
    afbp_pkg::cmd_t in_cmd;

    always_comb
    begin
        in_cmd.mode   = afbp_pkg::mode_t'(in_ch.mode);
        in_cmd.sample = in_ch.sample_in;
        in_cmd.last   = in_ch.last_of_block;
    end

    assign in_ch.ready = (count_reg != 2'(afbp_pkg::QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (count_reg != 2'd0);
    assign cmd         = q_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg + 2'(push) - 2'(cmd_pop);
        rd_next    = rd_reg ^ cmd_pop;
        wr_next    = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
            wr_reg    <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= in_cmd;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/afbp_back.sv -----
// ----------------------------------------------------------------------------
// afbp_back
// Executes push, pop and clear commands against the buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none
module afbp_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [afbp_pkg::CFG_W-1:0] cfg_data,
    input  wire afbp_pkg::cmd_t          cmd,
    input  wire logic                    cmd_valid,
    output logic                         cmd_pop,
    afbp_out_if.source                   out_ch
);
    logic [15:0] mem [afbp_pkg::NUM_BUFFERS * afbp_pkg::MAX_FRAME];
    logic [15:0] rdata_reg;
    logic [afbp_pkg::FILL_W-1:0] fill_reg [afbp_pkg::NUM_BUFFERS];
    logic [31:0] seq_reg [afbp_pkg::NUM_BUFFERS];
    logic [31:0] next_seq_reg;
    logic [afbp_pkg::OFF_W-1:0] pop_off_reg;
    logic drop_latch_reg, drop_latch_next;
    logic [afbp_pkg::LEN_W-1:0] frame_len_reg;
    logic capture_reg;
    afbp_pkg::back_state_t state_reg, state_next;
    afbp_pkg::result_t res_reg, res_next;
    logic [afbp_pkg::BUF_W-1:0] sel_reg;
    logic [afbp_pkg::OFF_W-1:0] off_reg;
    logic [afbp_pkg::FILL_W-1:0] len;
    logic [afbp_pkg::BUF_W-1:0] part_idx, empty_idx, full_idx;
    logic part_found, empty_found, full_found;
    logic [31:0] full_seq;
    logic [afbp_pkg::OFF_W-1:0] off_c;
    logic                       lvl_v   [afbp_pkg::NUM_BUFFERS];
    logic [31:0]                lvl_seq [afbp_pkg::NUM_BUFFERS];
    logic [afbp_pkg::BUF_W-1:0] lvl_idx [afbp_pkg::NUM_BUFFERS];

    always_comb
    begin
        if (frame_len_reg == '0)
            len = afbp_pkg::FILL_W'(1);
        else if (afbp_pkg::FILL_W'(frame_len_reg) > afbp_pkg::FILL_W'(afbp_pkg::MAX_FRAME))
            len = afbp_pkg::FILL_W'(afbp_pkg::MAX_FRAME);
        else
            len = afbp_pkg::FILL_W'(frame_len_reg);
    end

    // Priority searches over the descriptors (descending so lowest index wins).
    // The oldest full buffer is found by a pairwise tree; the lower-index side
    // keeps a tie.
    always_comb
    begin
        part_idx = '0; part_found = 1'b0;
        empty_idx = '0; empty_found = 1'b0;
        for (int i = afbp_pkg::NUM_BUFFERS - 1; i >= 0; i--)
        begin
            if (fill_reg[i] != '0 && fill_reg[i] < len)
            begin
                part_idx = afbp_pkg::BUF_W'(i); part_found = 1'b1;
            end
            if (fill_reg[i] == '0)
            begin
                empty_idx = afbp_pkg::BUF_W'(i); empty_found = 1'b1;
            end
        end
        for (int i = 0; i < afbp_pkg::NUM_BUFFERS; i++)
        begin
            lvl_v[i]   = (fill_reg[i] >= len);
            lvl_seq[i] = seq_reg[i];
            lvl_idx[i] = afbp_pkg::BUF_W'(i);
        end
        for (int lv = 0; lv < afbp_pkg::BUF_W; lv++)
        begin
            for (int i = 0; i < (afbp_pkg::NUM_BUFFERS >> (lv + 1)); i++)
            begin
                if (lvl_v[2*i+1] && (!lvl_v[2*i] || lvl_seq[2*i+1] < lvl_seq[2*i]))
                begin
                    lvl_v[i]   = 1'b1;
                    lvl_seq[i] = lvl_seq[2*i+1];
                    lvl_idx[i] = lvl_idx[2*i+1];
                end
                else
                begin
                    lvl_v[i]   = lvl_v[2*i];
                    lvl_seq[i] = lvl_seq[2*i];
                    lvl_idx[i] = lvl_idx[2*i];
                end
            end
        end
        full_found = lvl_v[0];
        full_seq   = lvl_seq[0];
        full_idx   = lvl_idx[0];
        off_c = (afbp_pkg::FILL_W'(pop_off_reg) > len - 1'b1)
              ? afbp_pkg::OFF_W'(len - 1'b1) : pop_off_reg;
    end

    // Result word and block-drop flag for the command taken in idle.
    always_comb
    begin
        res_next        = '0;
        drop_latch_next = drop_latch_reg;
        case (cmd.mode)
            afbp_pkg::MODE_PUSH:
            begin
                if (!capture_reg || drop_latch_reg)
                    res_next.dropped = 1'b1;
                else if (!part_found && !empty_found)
                begin
                    res_next.dropped = 1'b1;
                    drop_latch_next  = 1'b1;
                end
                if (cmd.last)
                    drop_latch_next = 1'b0;
            end
            afbp_pkg::MODE_POP:
            begin
                if (full_found)
                begin
                    res_next.valid         = 1'b1;
                    res_next.seq           = full_seq;
                    res_next.last_of_frame = (afbp_pkg::FILL_W'(off_c) + 1'b1 >= len);
                end
            end
            afbp_pkg::MODE_CLEAR: drop_latch_next = 1'b0;
            default: ;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        case (state_reg)
            afbp_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    state_next = (cmd.mode == afbp_pkg::MODE_POP && full_found)
                               ? afbp_pkg::ST_READ : afbp_pkg::ST_SEND;
                end
            end
            afbp_pkg::ST_READ: state_next = afbp_pkg::ST_SEND;
            afbp_pkg::ST_SEND: if (out_ch.ready) state_next = afbp_pkg::ST_IDLE;
            default:           state_next = afbp_pkg::ST_IDLE;
        endcase
    end

    assign out_ch.valid         = (state_reg == afbp_pkg::ST_SEND);
    assign out_ch.out_valid     = res_reg.valid;
    assign out_ch.sample_out    = res_reg.valid ? $signed(rdata_reg) : 16'sd0;
    assign out_ch.out_frame_seq = res_reg.seq;
    assign out_ch.last_of_frame = res_reg.last_of_frame;
    assign out_ch.push_dropped  = res_reg.dropped;

    always_ff @(posedge clk)
    begin
        if (state_reg == afbp_pkg::ST_IDLE && cmd_valid && cmd.mode == afbp_pkg::MODE_PUSH
            && capture_reg && !drop_latch_reg && (part_found || empty_found))
        begin
            if (part_found)
                mem[{part_idx, afbp_pkg::OFF_W'(fill_reg[part_idx])}] <= cmd.sample;
            else
                mem[{empty_idx, afbp_pkg::OFF_W'(0)}] <= cmd.sample;
        end
        if (state_reg == afbp_pkg::ST_READ)
            rdata_reg <= mem[{sel_reg, off_reg}];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= afbp_pkg::ST_IDLE;
            frame_len_reg  <= afbp_pkg::LEN_W'(160);
            capture_reg    <= 1'b0;
            next_seq_reg   <= '0;
            pop_off_reg    <= '0;
            drop_latch_reg <= 1'b0;
            res_reg        <= '0;
            sel_reg        <= '0;
            off_reg        <= '0;
            for (int i = 0; i < afbp_pkg::NUM_BUFFERS; i++)
            begin
                fill_reg[i] <= '0;
                seq_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == afbp_pkg::CFG_FRAME_LEN)
                    frame_len_reg <= cfg_data;
                else
                    capture_reg <= cfg_data[0];
            end
            if (state_reg == afbp_pkg::ST_IDLE && cmd_valid)
            begin
                res_reg        <= res_next;
                drop_latch_reg <= drop_latch_next;
                case (cmd.mode)
                    afbp_pkg::MODE_PUSH:
                    begin
                        if (capture_reg && !drop_latch_reg)
                        begin
                            if (part_found)
                                fill_reg[part_idx] <= fill_reg[part_idx] + 1'b1;
                            else if (empty_found)
                            begin
                                fill_reg[empty_idx] <= afbp_pkg::FILL_W'(1);
                                seq_reg[empty_idx]  <= next_seq_reg;
                                next_seq_reg        <= next_seq_reg + 32'd1;
                            end
                        end
                    end
                    afbp_pkg::MODE_POP:
                    begin
                        if (full_found)
                        begin
                            sel_reg <= full_idx;
                            off_reg <= off_c;
                            if (res_next.last_of_frame)
                            begin
                                fill_reg[full_idx] <= '0;
                                seq_reg[full_idx]  <= '0;
                                pop_off_reg        <= '0;
                            end
                            else
                                pop_off_reg <= off_c + 1'b1;
                        end
                    end
                    afbp_pkg::MODE_CLEAR:
                    begin
                        for (int i = 0; i < afbp_pkg::NUM_BUFFERS; i++)
                        begin
                            fill_reg[i] <= '0;
                            seq_reg[i]  <= '0;
                        end
                        next_seq_reg <= '0;
                        pop_off_reg  <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/audio_frame_buffer_pool_top.sv -----
// ----------------------------------------------------------------------------
// audio_frame_buffer_pool_top
// Pool of frame buffers that assembles audio samples into sequenced frames.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake    Word contents
// in_ch     sink       valid/ready  mode, sample_in, last_of_block
// out_ch    source     valid/ready  out_valid, sample_out, out_frame_seq,
//                                   last_of_frame, push_dropped
//
// A push, clear or empty pop goes from idle straight to the send state; a pop
// that returns a sample passes the read state first, a registered memory read.
// The front queue holds two words, so input is taken while a result waits.
// Reset empties every buffer and the counter; the sample memory is not cleared.
// An output stall holds the back end; the front keeps filling its queue.
// ----------------------------------------------------------------------------
`default_nettype none
module audio_frame_buffer_pool_top (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [0:0]                  cfg_index,
    input  wire logic [afbp_pkg::CFG_W-1:0]  cfg_data,
    afbp_in_if.sink                          in_ch,
    afbp_out_if.source                       out_ch
);
    afbp_pkg::cmd_t cmd;
    logic cmd_valid;
    logic cmd_pop;

    // The front end queues words so the back end can stall on its own.
    afbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // The back end owns the descriptors, the sample memory and the result.
    afbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );
endmodule
`default_nettype wire

// ----- hdl/afbp_checker.sv -----
// ----------------------------------------------------------------------------
// afbp_checker
// Port-level checks on the audio frame buffer pool.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module afbp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_v,
    input wire logic        out_r,
    input wire logic        out_valid,
    input wire logic        last_of_frame,
    input wire logic        push_dropped,
    input wire logic [15:0] sample_out
);
    `ASSERT_NEXT(a_hold, clk, rst_n, out_v && !out_r, out_v)
    `ASSERT_IMPL(a_last_valid, clk, rst_n, out_v && last_of_frame, out_valid)
    `ASSERT_IMPL(a_excl, clk, rst_n, out_v && push_dropped, !out_valid)
    `ASSERT_IMPL(a_zero, clk, rst_n, out_v && !out_valid, sample_out == 16'd0)
endmodule

bind audio_frame_buffer_pool_top afbp_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_v         (out_ch.valid),
    .out_r         (out_ch.ready),
    .out_valid     (out_ch.out_valid),
    .last_of_frame (out_ch.last_of_frame),
    .push_dropped  (out_ch.push_dropped),
    .sample_out    (out_ch.sample_out)
);
`default_nettype wire
